### design/sactc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactc_pkg
// Shared geometry, types and register codes of the set-associative cache
// tag controller.
// ----------------------------------------------------------------------------
package sactc_pkg;

    // cache geometry (powers of two)
    localparam int NUM_SETS    = 64;
    localparam int NUM_WAYS    = 4;
    localparam int BLOCK_BYTES = 64;

    localparam int ADDR_W   = 32;
    localparam int OFFSET_W = $clog2(BLOCK_BYTES);
    localparam int SET_W    = $clog2(NUM_SETS);
    localparam int TAG_W    = ADDR_W - OFFSET_W - SET_W;
    localparam int WAY_W    = $clog2(NUM_WAYS);
    localparam int RANK_W   = WAY_W;

    localparam int CLAT_W   = 8;
    localparam int MLAT_W   = 10;
    localparam int COST_W   = 12;
    localparam int CIDX_W   = 3;
    localparam int CDATA_W  = 10;

    // configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_WRITE_BACK     = 3'd0,
        CFG_WRITE_ALLOCATE = 3'd1,
        CFG_USE_LRU        = 3'd2,
        CFG_CACHE_LATENCY  = 3'd3,
        CFG_MEMORY_LATENCY = 3'd4
    } t_cfg_idx;

    // configuration register values
    typedef struct packed {
        logic              write_back;
        logic              write_allocate;
        logic              use_lru;
        logic [CLAT_W-1:0] cache_latency;
        logic [MLAT_W-1:0] memory_latency;
    } t_cfg;

    // one way of a set row
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic              dirty;
        logic [RANK_W-1:0] rank;
    } t_way;

    typedef t_way [NUM_WAYS-1:0] t_row;

    // result of one request
    typedef struct packed {
        logic              hit;
        logic [COST_W-1:0] cost;
        logic              wrote_back;
        logic              allocated;
    } t_result;

endpackage

### design/set_assoc_cache_tag_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller
// Set-associative tag controller: address split, tag lookup, LRU or FIFO
// replacement, write-back or write-through with optional write allocate.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+--------------------------
//   request  | in        | i_in_valid/o_in_ready  | i_action, i_address
//   result   | out       | o_out_valid/i_out_ready| o_hit, o_cost,
//            |           |                        | o_wrote_back, o_allocated
//   config   | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// One request per cycle while the result is not stalled. A request passes
// the request register, then the result register: the set row is read into
// the request register at acceptance, and the lookup loads the result
// register when it fires. Back-to-back requests to one set use the row just
// written (forward register). Reset clears all valid bits, no clearing pass.
// A stalled result holds the lookup stage and so the request side.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_controller
    import sactc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic [ADDR_W-1:0]  i_address,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_hit,
    output logic [COST_W-1:0]  o_cost,
    output logic               o_wrote_back,
    output logic               o_allocated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CIDX_W-1:0]  i_cfg_index,
    input  logic [CDATA_W-1:0] i_cfg_data
);

    t_cfg                 cfg;
    logic                 in_accept;
    logic                 s1_fire;
    logic [SET_W-1:0]     in_set;
    t_row                 s1_row;
    t_row                 lk_row;
    logic [NUM_WAYS-1:0]  lk_valid;
    t_result              lk_result;

    logic                 r_s1_valid;
    logic                 r_s1_store;
    logic [SET_W-1:0]     r_s1_set;
    logic [TAG_W-1:0]     r_s1_tag;
    t_row                 r_rd_row;
    logic                 r_fwd_valid;
    logic [SET_W-1:0]     r_fwd_set;
    t_row                 r_fwd_row;
    logic                 r_out_valid;
    t_result              r_result;
    logic [NUM_WAYS-1:0]  r_valid_bits [NUM_SETS];
    t_row                 mem [NUM_SETS];

    // configuration registers
    sactc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );
    assign o_cfg_ready = 1'b1;

    // handshake
    assign s1_fire    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_accept  = i_in_valid && o_in_ready;
    assign in_set     = i_address[OFFSET_W +: SET_W];

    // set row: latest write wins over the registered read
    assign s1_row = (r_fwd_valid && r_fwd_set == r_s1_set) ? r_fwd_row : r_rd_row;

    sactc_lookup u_lookup (
        .i_row    (s1_row),
        .i_valid  (r_valid_bits[r_s1_set]),
        .i_tag    (r_s1_tag),
        .i_store  (r_s1_store),
        .i_cfg    (cfg),
        .o_row    (lk_row),
        .o_valid  (lk_valid),
        .o_result (lk_result)
    );

    // control state and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
            for (int s = 0; s < NUM_SETS; s++) begin
                r_valid_bits[s] <= '0;
            end
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid              <= 1'b1;
                r_fwd_valid              <= 1'b1;
                r_valid_bits[r_s1_set]   <= lk_valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request register and set-row read
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_store <= i_action;
            r_s1_set   <= in_set;
            r_s1_tag   <= i_address[ADDR_W-1 -: TAG_W];
            r_rd_row   <= mem[in_set];
        end
    end

    // set-row write, forward register and result register
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            mem[r_s1_set] <= lk_row;
            r_fwd_set     <= r_s1_set;
            r_fwd_row     <= lk_row;
            r_result      <= lk_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_result.hit;
    assign o_cost       = r_result.cost;
    assign o_wrote_back = r_result.wrote_back;
    assign o_allocated  = r_result.allocated;

endmodule

### design/sactc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactc_cfg_regs
// Policy and latency registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module sactc_cfg_regs
    import sactc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [CIDX_W-1:0]  i_cfg_index,
    input  logic [CDATA_W-1:0] i_cfg_data,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.write_back     <= 1'b1;
            r_cfg.write_allocate <= 1'b1;
            r_cfg.use_lru        <= 1'b1;
            r_cfg.cache_latency  <= CLAT_W'(1);
            r_cfg.memory_latency <= MLAT_W'(100);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WRITE_BACK:     r_cfg.write_back     <= i_cfg_data[0];
                CFG_WRITE_ALLOCATE: r_cfg.write_allocate <= i_cfg_data[0];
                CFG_USE_LRU:        r_cfg.use_lru        <= i_cfg_data[0];
                CFG_CACHE_LATENCY:  r_cfg.cache_latency  <= i_cfg_data[CLAT_W-1:0];
                CFG_MEMORY_LATENCY: r_cfg.memory_latency <= i_cfg_data[MLAT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/sactc_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactc_lookup
// Tag compare, victim choice, replacement-order update and cost for one
// request against one set row.
// ----------------------------------------------------------------------------
module sactc_lookup
    import sactc_pkg::*;
(
    input  t_row                i_row,
    input  logic [NUM_WAYS-1:0] i_valid,
    input  logic [TAG_W-1:0]    i_tag,
    input  logic                i_store,
    input  t_cfg                i_cfg,
    output t_row                o_row,
    output logic [NUM_WAYS-1:0] o_valid,
    output t_result             o_result
);

    logic [NUM_WAYS-1:0] hit_vec;
    logic                hit;
    logic [WAY_W-1:0]    hit_way;
    logic                has_free;
    logic [WAY_W-1:0]    free_way;
    logic [WAY_W-1:0]    victim_way;
    logic [WAY_W-1:0]    fill_way;
    logic [RANK_W:0]     fill_age;
    logic                victim_dirty;
    logic                do_fill;
    logic [COST_W-1:0]   c_cost;
    logic [COST_W-1:0]   m_cost;

    // tag compare and free-way search
    always_comb begin
        hit_vec  = '0;
        hit      = 1'b0;
        hit_way  = '0;
        has_free = 1'b0;
        free_way = '0;
        for (int i = NUM_WAYS - 1; i >= 0; i--) begin
            hit_vec[i] = i_valid[i] && (i_row[i].tag == i_tag);
            if (hit_vec[i]) begin
                hit_way = WAY_W'(i);
            end
            if (!i_valid[i]) begin
                has_free = 1'b1;
                free_way = WAY_W'(i);
            end
        end
        hit = |hit_vec;
    end

    // oldest way, lowest index on a tie
    always_comb begin
        victim_way = '0;
        for (int i = 1; i < NUM_WAYS; i++) begin
            if (i_row[i].rank > i_row[victim_way].rank) begin
                victim_way = WAY_W'(i);
            end
        end
    end

    assign fill_way     = has_free ? free_way : victim_way;
    assign fill_age     = has_free ? (RANK_W+1)'(NUM_WAYS)
                                   : {1'b0, i_row[victim_way].rank};
    assign victim_dirty = !has_free && i_row[victim_way].dirty;
    assign do_fill      = !hit && (!i_store || i_cfg.write_allocate);

    assign c_cost = COST_W'(i_cfg.cache_latency);
    assign m_cost = COST_W'(i_cfg.memory_latency);

    // row update and cost
    always_comb begin
        o_row               = i_row;
        o_valid             = i_valid;
        o_result.hit        = hit;
        o_result.wrote_back = 1'b0;
        o_result.allocated  = 1'b0;
        o_result.cost       = c_cost + m_cost;
        if (hit) begin
            if (i_store && i_cfg.write_back) begin
                o_result.cost         = c_cost + c_cost;
                o_row[hit_way].dirty  = 1'b1;
            end else begin
                o_result.cost = c_cost;
            end
            if (i_cfg.use_lru) begin
                for (int i = 0; i < NUM_WAYS; i++) begin
                    if (WAY_W'(i) != hit_way && i_valid[i]
                            && i_row[i].rank < i_row[hit_way].rank) begin
                        o_row[i].rank = i_row[i].rank + RANK_W'(1);
                    end
                end
                o_row[hit_way].rank = '0;
            end
        end else if (do_fill) begin
            for (int i = 0; i < NUM_WAYS; i++) begin
                if (WAY_W'(i) != fill_way && i_valid[i]
                        && {1'b0, i_row[i].rank} < fill_age) begin
                    o_row[i].rank = i_row[i].rank + RANK_W'(1);
                end
            end
            o_valid[fill_way]    = 1'b1;
            o_row[fill_way].tag  = i_tag;
            o_row[fill_way].rank = '0;
            o_row[fill_way].dirty = i_store && i_cfg.write_back;
            o_result.allocated   = 1'b1;
            if (i_cfg.write_back) begin
                o_result.wrote_back = victim_dirty;
                o_result.cost = c_cost + c_cost + m_cost
                              + (victim_dirty ? m_cost : '0);
            end else if (i_store) begin
                o_result.cost = c_cost + c_cost + m_cost + m_cost;
            end else begin
                o_result.cost = c_cost + c_cost + m_cost;
            end
        end
    end

endmodule

### design/sactc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sactc_checker
// Port-level checks of the tag controller, bound to the top level.
// ----------------------------------------------------------------------------
module sactc_checker
    import sactc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_hit,
    input logic [COST_W-1:0] o_cost,
    input logic              o_wrote_back,
    input logic              o_allocated
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a hit never fills a line
    a_hit_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_allocated))
        else $error("hit with allocation");

    // a write-back only comes with a fill
    a_wb_needs_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_wrote_back) |-> (o_allocated && !o_hit))
        else $error("write-back without fill");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_cost) && $stable(o_hit)))
        else $error("stalled result changed");

endmodule

bind set_assoc_cache_tag_controller sactc_checker u_sactc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_hit        (o_hit),
    .o_cost       (o_cost),
    .o_wrote_back (o_wrote_back),
    .o_allocated  (o_allocated)
);
